[hdl/cfs_pkg.sv]
package cfs_pkg;

   localparam int LEN_W               = 6;
   localparam int BYTE_W              = 8;
   localparam int IDX_W               = 8;
   localparam int DEF_MAX_FIELD_BYTES = 32;
   localparam logic [LEN_W-1:0] LIMIT_RESET = 6'd32;

   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

   localparam logic ACT_DATA = 1'b0;
   localparam logic ACT_EOL  = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
      logic rd_issue;
      logic flush_emit;
   } cfs_cmd_type;

   typedef struct packed {
      logic step_emits;
      logic step_done;
      logic need_flush;
      logic flush_last;
      logic out_free;
   } cfs_stat_type;

endpackage

[hdl/cfs_ram.sv]
module cfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

[hdl/cfs_ctrl.sv]
module cfs_ctrl
   import cfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  cfs_stat_type stat,
   output cfs_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH_RD,
      ST_FLUSH_OUT
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (stat.need_flush) begin
               state_in = ST_FLUSH_RD;
            end else if (!stat.step_emits || stat.out_free) begin
               cmd.step = 1'b1;
               if (stat.step_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_FLUSH_OUT;
         end
         ST_FLUSH_OUT: begin
            if (stat.out_free) begin
               cmd.flush_emit = 1'b1;
               state_in = stat.flush_last ? ST_STEP : ST_FLUSH_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/cfs_datapath.sv]
module cfs_datapath
   import cfs_pkg::*;
#(
   parameter int MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tuser,
   input  logic [7:0]        req_tdata,
   input  logic              csr_valid,
   input  logic [LEN_W-1:0]  csr_data,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   input  cfs_cmd_type       cmd,
   output cfs_stat_type      stat
);

   localparam int ADDR_W = (MAX_FIELD_BYTES > 1) ? $clog2(MAX_FIELD_BYTES) : 1;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD_BYTES);
   localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

   typedef enum logic [2:0] {
      M_START,
      M_UNQ,
      M_QUO,
      M_AFTERQ,
      M_SWALLOW,
      M_DROP
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              act_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  held_ff, held_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  ptr_ff;
   logic [LEN_W-1:0]  limit_ff;
   logic [LEN_W-1:0]  lim;
   logic [LEN_W-1:0]  len_inc;

   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] r_byte_ff;
   logic              r_has_ff, r_fend_ff, r_lend_ff, r_last_ff;
   logic [IDX_W-1:0]  r_idx_ff;

   logic              is_blank, is_comma, is_quote, at_limit;
   logic              emit, e_has, e_fend, e_lend, e_last, done, close, push;
   logic [BYTE_W-1:0] ram_rd_data;

   assign is_blank = ((byte_ff >= CHAR_TAB) && (byte_ff <= CHAR_CR)) ||
                     (byte_ff == CHAR_SPACE);
   assign is_comma = (byte_ff == CHAR_COMMA);
   assign is_quote = (byte_ff == CHAR_QUOTE);
   assign lim      = (limit_ff == '0) ? ONE : ((limit_ff > MAX_LEN) ? MAX_LEN : limit_ff);
   assign at_limit = (len_ff >= lim);
   assign len_inc  = len_ff + ONE;

   always_comb begin
      emit    = 1'b0;
      e_has   = 1'b0;
      e_fend  = 1'b0;
      e_lend  = 1'b0;
      e_last  = 1'b1;
      done    = 1'b1;
      close   = 1'b0;
      push    = 1'b0;
      mode_in = mode_ff;
      len_in  = len_ff;
      held_in = held_ff;
      cnt_in  = cnt_ff;
      if (act_ff == ACT_EOL) begin
         emit    = 1'b1;
         e_fend  = (mode_ff == M_UNQ) || (mode_ff == M_QUO);
         e_lend  = 1'b1;
         mode_in = M_START;
         len_in  = '0;
         held_in = '0;
         cnt_in  = '0;
      end else begin
         unique case (mode_ff)
            M_UNQ: begin
               if (is_comma) begin
                  emit    = 1'b1;
                  e_fend  = 1'b1;
                  close   = 1'b1;
                  mode_in = M_START;
               end else if (at_limit) begin
                  emit    = 1'b1;
                  e_fend  = 1'b1;
                  e_last  = is_blank || is_quote;
                  close   = 1'b1;
                  mode_in = M_SWALLOW;
                  done    = 1'b0;
               end else if (is_blank) begin
                  push    = 1'b1;
                  held_in = held_ff + ONE;
                  len_in  = len_inc;
                  if (len_inc >= lim) begin
                     emit    = 1'b1;
                     e_fend  = 1'b1;
                     close   = 1'b1;
                     mode_in = M_SWALLOW;
                  end
               end else begin
                  held_in = '0;
                  len_in  = len_inc;
                  emit    = 1'b1;
                  e_has   = 1'b1;
                  if (len_inc >= lim) begin
                     e_fend  = 1'b1;
                     close   = 1'b1;
                     mode_in = M_SWALLOW;
                  end
               end
            end
            M_QUO: begin
               if (is_quote) begin
                  emit    = 1'b1;
                  e_fend  = 1'b1;
                  close   = 1'b1;
                  mode_in = M_AFTERQ;
               end else if (at_limit) begin
                  emit    = 1'b1;
                  e_fend  = 1'b1;
                  close   = 1'b1;
                  mode_in = M_DROP;
                  done    = 1'b0;
               end else begin
                  len_in = len_inc;
                  emit   = 1'b1;
                  e_has  = 1'b1;
                  if (len_inc >= lim) begin
                     e_fend  = 1'b1;
                     close   = 1'b1;
                     mode_in = M_DROP;
                  end
               end
            end
            M_AFTERQ: begin
               if (!is_blank) begin
                  mode_in = M_START;
                  done    = is_comma;
               end
            end
            M_SWALLOW: begin
               mode_in = M_START;
               done    = is_comma;
            end
            M_DROP: begin
               mode_in = is_quote ? M_AFTERQ : M_START;
            end
            default: begin
               mode_in = M_START;
               if (is_blank) begin
                  mode_in = M_START;
               end else if (is_comma) begin
                  emit   = 1'b1;
                  e_fend = 1'b1;
                  close  = 1'b1;
               end else if (is_quote) begin
                  mode_in = M_QUO;
                  len_in  = '0;
                  held_in = '0;
               end else begin
                  mode_in = M_UNQ;
                  len_in  = '0;
                  held_in = '0;
                  done    = 1'b0;
               end
            end
         endcase
         if (close) begin
            len_in  = '0;
            held_in = '0;
            cnt_in  = (cnt_ff == '1) ? cnt_ff : cnt_ff + IDX_W'(1);
         end
      end
   end

   assign stat.step_emits = emit;
   assign stat.step_done  = done;
   assign stat.need_flush = (act_ff == ACT_DATA) && (mode_ff == M_UNQ) && !is_comma &&
                            !at_limit && !is_blank && (held_ff != ptr_ff);
   assign stat.flush_last = ((ptr_ff + ONE) == held_ff);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   cfs_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_FIELD_BYTES)
   ) u_held (
      .clock      (clock),
      .wr_en      (cmd.step && push),
      .wr_addr    (held_ff[ADDR_W-1:0]),
      .wr_data    (byte_ff),
      .rd_en      (cmd.rd_issue),
      .rd_addr    (ptr_ff[ADDR_W-1:0]),
      .rd_data_ff (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_START;
         len_ff       <= '0;
         held_ff      <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (cmd.load) begin
            ptr_ff <= '0;
         end else if (cmd.flush_emit) begin
            ptr_ff <= ptr_ff + ONE;
         end
         if (cmd.step) begin
            mode_ff <= mode_in;
            len_ff  <= len_in;
            held_ff <= held_in;
            cnt_ff  <= cnt_in;
         end
         if ((cmd.step && emit) || cmd.flush_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_tdata;
         act_ff  <= req_tuser;
      end
      if (cmd.flush_emit) begin
         r_byte_ff <= ram_rd_data;
         r_has_ff  <= 1'b1;
         r_fend_ff <= 1'b0;
         r_lend_ff <= 1'b0;
         r_last_ff <= 1'b0;
         r_idx_ff  <= cnt_ff;
      end else if (cmd.step && emit) begin
         r_byte_ff <= e_has ? byte_ff : '0;
         r_has_ff  <= e_has;
         r_fend_ff <= e_fend;
         r_lend_ff <= e_lend;
         r_last_ff <= e_last;
         r_idx_ff  <= cnt_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {r_idx_ff, r_byte_ff};
   assign rsp_tuser  = {r_lend_ff, r_fend_ff, r_has_ff};
   assign rsp_tlast  = r_last_ff;

endmodule

[hdl/csv_field_splitter.sv]
// channel   dir  handshake                payload
// req       in   req_tvalid/req_tready    tdata = in_byte, tuser = action
// rsp       out  rsp_tvalid/rsp_tready    tdata = out_byte, field_index; tuser; tlast = last
// csr       in   csr_valid/csr_ready      csr_data = field_limit
//
// An item is accepted, then taken through one to four parse steps, plus a start state
// for a held-blank replay and a read state and an emit state per blank replayed.
// Sync active-high reset returns to field start; field_limit resets to 32.
// A low rsp_tready with a result pending holds the result register and stalls any step that emits.
// Bytes are accepted only while no item is in progress.
module csv_field_splitter
   import cfs_pkg::*;
#(
   parameter int MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] in_byte
   input  logic             req_tuser,   // [0] action
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_byte, [15:8] field_index
   output logic [2:0]       rsp_tuser,   // [0] has_byte, [1] field_end, [2] line_end
   output logic             rsp_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_data
);

   cfs_cmd_type  cmd;
   cfs_stat_type stat;

   assign csr_ready = 1'b1;

   cfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cfs_datapath #(
      .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

[hdl/cfs_checker.sv]
module cfs_checker
   import cfs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [7:0]       req_tdata,
   input logic             req_tuser,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [15:0]      rsp_tdata,
   input logic [2:0]       rsp_tuser,
   input logic             rsp_tlast,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic [LEN_W-1:0] csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast && !rsp_tuser[0])
      else $error("line end beat must be final and carry no byte");

   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[7:0] == 8'h00))
      else $error("out_byte nonzero without has_byte");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) &&
      $stable(req_tuser))
      else $error("req beat changed while stalled");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready && !$isunknown(csr_data))
      else $error("csr write not taken or data unknown");

endmodule

bind csv_field_splitter cfs_checker u_cfs_checker (.*);
